>>> hdl/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants for the multichannel PWM with dead time.
// ----------------------------------------------------------------------------
package mpwm_pkg;

	localparam int CHANNELS         = 8;
	localparam int PIN_BITS         = 16;
	localparam int OP_W             = 2;
	localparam int CHAN_W           = 3;
	localparam int DUTY_W           = 8;
	localparam int DIR_W            = 2;
	localparam int DEAD_W           = 16;
	localparam int DELAY_W          = 31;
	localparam int MS_W             = 32;
	localparam int PERIOD_W         = 8;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd100;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_DELAY = 2'd2
	} mpwm_op_t;

	// One decoded item as it leaves the input register.
	typedef struct packed {
		logic                tick;
		logic                set;
		logic                start;
		logic [CHAN_W-1:0]   channel;
		logic                enable;
		logic [DUTY_W-1:0]   duty;
		logic [DIR_W-1:0]    direction;
		logic [DEAD_W-1:0]   dead_time;
		logic [DELAY_W-1:0]  delay_length;
	} mpwm_cmd_t;

endpackage

>>> hdl/mpwm_chan.sv
// ----------------------------------------------------------------------------
// mpwm_chan
// State and pin logic of one motor channel: enable, duty, directions,
// dead-time counter and the two pin levels.
// ----------------------------------------------------------------------------
module mpwm_chan
	import mpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 sel,
	input  mpwm_cmd_t            cmd,
	input  logic [PERIOD_W-1:0]  period_count,
	output logic [DIR_W-1:0]     pins_next
);

	logic               enable_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [DIR_W-1:0]   live_q;
	logic [DIR_W-1:0]   saved_q;
	logic [DEAD_W-1:0]  dead_q;
	logic [DIR_W-1:0]   pins_q;

	logic               dead_expire;
	logic [DIR_W-1:0]   live_tick;
	logic               do_set;

	// The counter reaches zero on this tick when it holds one.
	assign dead_expire = (dead_q == DEAD_W'(1));
	assign live_tick   = dead_expire ? saved_q : live_q;
	assign do_set      = cmd.set && sel;

	always_comb begin
		pins_next = pins_q;
		if (cmd.tick) begin
			if (period_count == '0) begin
				if (enable_q) begin
					pins_next = live_tick;
				end
			end else if (duty_q == period_count) begin
				pins_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			duty_q   <= '0;
			live_q   <= '0;
			saved_q  <= '0;
			dead_q   <= '0;
			pins_q   <= '0;
		end else if (fire) begin
			pins_q <= pins_next;
			if (cmd.tick) begin
				if (dead_q != '0) begin
					dead_q <= dead_q - DEAD_W'(1);
				end
				live_q <= live_tick;
			end else if (do_set) begin
				enable_q <= cmd.enable;
				duty_q   <= cmd.duty;
				saved_q  <= cmd.direction;
				dead_q   <= cmd.dead_time;
				if (cmd.dead_time == '0) begin
					live_q <= cmd.direction;
				end
			end
		end
	end

endmodule

>>> hdl/mpwm_timer.sv
// ----------------------------------------------------------------------------
// mpwm_timer
// PWM period counter, wrapping millisecond counter and delay counter.
// ----------------------------------------------------------------------------
module mpwm_timer
	import mpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  mpwm_cmd_t            cmd,
	input  logic [PERIOD_W-1:0]  pwm_period,
	output logic [PERIOD_W-1:0]  period_count,
	output logic [MS_W-1:0]      ms_next,
	output logic                 delay_active_next
);

	logic [PERIOD_W-1:0]  count_q;
	logic [MS_W-1:0]      ms_q;
	logic [DELAY_W-1:0]   delay_q;

	logic [PERIOD_W-1:0]  count_inc;
	logic                 wrap;
	logic [PERIOD_W-1:0]  count_next;
	logic [DELAY_W-1:0]   delay_next;

	assign period_count = count_q;
	assign count_inc    = count_q + PERIOD_W'(1);
	assign wrap         = cmd.tick && (count_inc == pwm_period);

	always_comb begin
		count_next = count_q;
		ms_next    = ms_q;
		delay_next = delay_q;
		if (cmd.tick) begin
			count_next = wrap ? '0 : count_inc;
			if (wrap) begin
				ms_next = ms_q + MS_W'(1);
				if (delay_q != '0) begin
					delay_next = delay_q - DELAY_W'(1);
				end
			end
		end else if (cmd.start) begin
			delay_next = cmd.delay_length;
		end
	end

	assign delay_active_next = (delay_next != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ms_q    <= '0;
			delay_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
			ms_q    <= ms_next;
			delay_q <= delay_next;
		end
	end

endmodule

>>> hdl/multichannel_pwm_with_deadtime.sv
// Path: an accepted item is held in the input register, then its result in the
// result register; the item waits while a finished result is held by out_stall.
// Throughput: one item per cycle unless a held result stalls the input; the whole
// state update is one pass of compares and decrements between the two registers.
// Reset: all counters, channel settings and channel pins clear, pwm_period loads 100.
// ----------------------------------------------------------------------------
// multichannel_pwm_with_deadtime
// Eight-channel PWM with per-channel dead time, millisecond and delay timers.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_deadtime
	import mpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [PERIOD_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [CHAN_W-1:0]    channel,
	input  logic                 enable,
	input  logic [DUTY_W-1:0]    duty,
	input  logic [DIR_W-1:0]     direction,
	input  logic [DEAD_W-1:0]    dead_time,
	input  logic [DELAY_W-1:0]   delay_length,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIN_BITS-1:0]  pin_levels,
	output logic [MS_W-1:0]      millisecond_count,
	output logic                 delay_active
);

	logic [PERIOD_W-1:0]  pwm_period_q;
	logic                 s1_valid;
	mpwm_cmd_t            cmd_s1;
	mpwm_cmd_t            cmd_in;
	logic                 advance;
	logic                 accept;
	logic                 out_valid_q;
	logic [PIN_BITS-1:0]  pins_q;
	logic [MS_W-1:0]      ms_q;
	logic                 delay_active_q;

	logic [PERIOD_W-1:0]  period_count;
	logic [MS_W-1:0]      ms_next;
	logic                 delay_active_next;
	logic [DIR_W-1:0]     chan_pins [CHANNELS];
	logic [PIN_BITS-1:0]  pins_all;

	// The item in the input register moves on when the result register is
	// empty or its result is being taken.
	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd_in              = '0;
		cmd_in.tick         = (operation == OP_TICK);
		cmd_in.set          = (operation == OP_SET);
		cmd_in.start        = (operation == OP_DELAY);
		cmd_in.channel      = channel;
		cmd_in.enable       = enable;
		cmd_in.duty         = duty;
		cmd_in.direction    = direction;
		cmd_in.dead_time    = dead_time;
		cmd_in.delay_length = delay_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			pwm_period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

	mpwm_timer u_timer (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (advance),
		.cmd               (cmd_s1),
		.pwm_period        (pwm_period_q),
		.period_count      (period_count),
		.ms_next           (ms_next),
		.delay_active_next (delay_active_next)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		mpwm_chan u_chan (
			.clk          (clk),
			.arst_n       (arst_n),
			.fire         (advance),
			.sel          (32'(cmd_s1.channel) == c),
			.cmd          (cmd_s1),
			.period_count (period_count),
			.pins_next    (chan_pins[c])
		);
	end

	// Channels beyond the pin register have no pin bits.
	always_comb begin
		pins_all = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (c < PIN_BITS / DIR_W) begin
				pins_all[c*DIR_W +: DIR_W] = chan_pins[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_q         <= pins_all;
			ms_q           <= ms_next;
			delay_active_q <= delay_active_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign pin_levels        = pins_q;
	assign millisecond_count = ms_q;
	assign delay_active      = delay_active_q;

endmodule

>>> hdl/mpwm_checker.sv
// ----------------------------------------------------------------------------
// mpwm_checker
// Port-level checks for the multichannel PWM, bound to the top level.
// ----------------------------------------------------------------------------
module mpwm_checker
	import mpwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [PIN_BITS-1:0]  pin_levels,
	input  logic [MS_W-1:0]      millisecond_count,
	input  logic                 delay_active
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pin_levels) && $stable(millisecond_count)
			&& $stable(delay_active))
		else $error("stalled result changed");

	// The input side only stalls when a finished result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// A new result appears only after an accepted item has passed the input register.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted item");

endmodule

bind multichannel_pwm_with_deadtime mpwm_checker u_mpwm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.pin_levels        (pin_levels),
	.millisecond_count (millisecond_count),
	.delay_active      (delay_active)
);
